>>> rtl/core/bdpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bdpc_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned CountW = 32;
	localparam int unsigned CfgW = 16;
	localparam int unsigned CfgIdxW = 2;

	typedef logic [TimeW-1:0] time_ms_t;
	typedef logic [CountW-1:0] count_t;
	typedef logic [CfgW-1:0] cfg_val_t;
	typedef logic [CfgIdxW-1:0] cfg_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t CFG_DEBOUNCE = 2'd0;
	localparam cfg_idx_t CFG_LONG_PRESS = 2'd1;
	localparam cfg_idx_t CFG_BLINK_PERIOD = 2'd2;

	// Configuration values after reset.
	localparam cfg_val_t DEBOUNCE_RST = 16'd30;
	localparam cfg_val_t LONG_PRESS_RST = 16'd700;
	localparam cfg_val_t BLINK_PERIOD_RST = 16'd500;

endpackage

`default_nettype wire

>>> rtl/core/button_debounce_press_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

// Debounced push-button with press/release classification and a status blink.
// Every input transaction carries one button sample (1 means pressed) and a
// wrapping millisecond timestamp, and produces exactly one output transaction.
// A raw level that differs from the debounced level is accepted once it has
// held for the debounce time since the last raw change; an accepted press
// counts, stamps its time and toggles ring_on, and an accepted release reports
// the held time and flags it long when it reaches the long-press threshold.
// The blink level toggles whenever the blink period has passed since its
// previous toggle. All time differences wrap modulo 2^32, and the first sample
// after reset seeds the raw and debounced levels. The block takes one sample
// per clock cycle unless in_stall holds it: a sample is captured in an input
// register, evaluated against the state by one pass of subtract-and-compare
// logic, and lands in the result register. A new input transaction is taken
// while a finished result waits, as long as the input register can move on.
// Configuration writes (index 0 debounce time, 1 long-press threshold,
// 2 blink period, others ignored) are expected only while the block is idle.
module button_debounce_press_classifier
	import bdpc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,

	input  wire logic             cfg_we,
	input  wire cfg_idx_t         cfg_index,
	input  wire cfg_val_t         cfg_data,

	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             button_down,
	input  wire time_ms_t         now_ms,

	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic                  press_event,
	output logic                  release_event,
	output logic                  long_press,
	output time_ms_t              held_ms,
	output logic                  ring_on,
	output logic                  blink_on,
	output count_t                press_total,
	output count_t                bounce_total
);

	// Configuration registers.
	cfg_val_t debounce_q, long_press_q, blink_period_q;

	// Input register stage.
	logic     valid_s1;
	logic     button_s1;
	time_ms_t now_s1;

	// Debounce and classification state.
	logic     primed_q, raw_prev_q, stable_q, ring_q, blink_q;
	time_ms_t change_time_q, press_time_q, blink_time_q;
	count_t   press_cnt_q, bounce_cnt_q;

	// Result register stage.
	logic     valid_s2;
	logic     press_s2, release_s2, long_s2, ring_s2, blink_s2;
	time_ms_t held_s2;
	count_t   press_tot_s2, bounce_tot_s2;

	// Evaluation of the sample held in the input register.
	logic     adv;
	logic     eff_raw_prev, eff_stable, flip, bounce, accept, blink_hit;
	logic     press_d, release_d, long_d;
	time_ms_t eff_change, change_d, since_change, held_d, since_blink;
	count_t   press_cnt_d, bounce_cnt_d;

	// The sample in stage 1 moves to the result register when that register
	// is empty or its current transaction is taken in this cycle.
	assign adv = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_comb begin
		// Before the first sample, the sample itself seeds the levels.
		eff_raw_prev = primed_q ? raw_prev_q : button_s1;
		eff_stable = primed_q ? stable_q : button_s1;
		eff_change = primed_q ? change_time_q : now_s1;

		flip = button_s1 != eff_raw_prev;
		change_d = flip ? now_s1 : eff_change;
		bounce = flip && (button_s1 != eff_stable);
		bounce_cnt_d = bounce_cnt_q + (bounce ? count_t'(1) : count_t'(0));

		since_change = now_s1 - change_d;
		accept = (button_s1 != eff_stable)
			&& (since_change >= time_ms_t'(debounce_q));

		press_d = accept && button_s1;
		release_d = accept && !button_s1;
		held_d = release_d ? (now_s1 - press_time_q) : '0;
		long_d = release_d && (held_d >= time_ms_t'(long_press_q));
		press_cnt_d = press_cnt_q + (press_d ? count_t'(1) : count_t'(0));

		since_blink = now_s1 - blink_time_q;
		blink_hit = since_blink >= time_ms_t'(blink_period_q);
	end

	// Configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
			blink_period_q <= BLINK_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEBOUNCE: begin
					debounce_q <= cfg_data;
				end
				CFG_LONG_PRESS: begin
					long_press_q <= cfg_data;
				end
				CFG_BLINK_PERIOD: begin
					blink_period_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			button_s1 <= button_down;
			now_s1 <= now_ms;
		end
	end

	// State update, once per evaluated sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
			raw_prev_q <= 1'b0;
			stable_q <= 1'b0;
			ring_q <= 1'b0;
			blink_q <= 1'b0;
			change_time_q <= '0;
			press_time_q <= '0;
			blink_time_q <= '0;
			press_cnt_q <= '0;
			bounce_cnt_q <= '0;
		end else if (adv) begin
			primed_q <= 1'b1;
			raw_prev_q <= button_s1;
			change_time_q <= change_d;
			bounce_cnt_q <= bounce_cnt_d;
			press_cnt_q <= press_cnt_d;
			if (accept) begin
				stable_q <= button_s1;
			end else begin
				stable_q <= eff_stable;
			end
			if (press_d) begin
				press_time_q <= now_s1;
				ring_q <= !ring_q;
			end
			if (blink_hit) begin
				blink_time_q <= now_s1;
				blink_q <= !blink_q;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			press_s2 <= press_d;
			release_s2 <= release_d;
			long_s2 <= long_d;
			held_s2 <= held_d;
			ring_s2 <= ring_q ^ press_d;
			blink_s2 <= blink_q ^ blink_hit;
			press_tot_s2 <= press_cnt_d;
			bounce_tot_s2 <= bounce_cnt_d;
		end
	end

	assign out_valid = valid_s2;
	assign press_event = press_s2;
	assign release_event = release_s2;
	assign long_press = long_s2;
	assign held_ms = held_s2;
	assign ring_on = ring_s2;
	assign blink_on = blink_s2;
	assign press_total = press_tot_s2;
	assign bounce_total = bounce_tot_s2;

	// A result never reports a press and a release at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(press_s2 && release_s2))
		else $error("press and release in one result");

	// Held time and the long flag are only reported with a release.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !release_s2) |-> (held_s2 == '0 && !long_s2))
		else $error("held time or long flag without a release");

	// The ring level flips exactly on an accepted press.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (ring_q == ($past(ring_q) ^ $past(press_d))))
		else $error("ring level out of step with presses");

	// The bounce counter advances by at most one per sample.
	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> ((bounce_cnt_q - $past(bounce_cnt_q)) <= count_t'(1)))
		else $error("bounce counter jumped");

	// A held result is never overwritten while it waits.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && out_stall) |-> !adv)
		else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
